// File: hw/rtl/utf8_byte_stream_decoder_assert.svh
// ---------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared property forms for the decoder's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef UTF8_BYTE_STREAM_DECODER_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define UTF8D_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 decoder check failed");

// Next-cycle implication, disabled while reset is high.
`define UTF8D_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 decoder check failed");

`endif

// File: hw/rtl/utf8d_pkg.sv
// ---------------------------------------------------------------------------
// UTF-8 decoder package
// Widths, state and step types shared by the decoder files.
// ---------------------------------------------------------------------------
package utf8d_pkg;

  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 31;
  localparam int PEND_W  = 3;
  localparam int CONT_W  = 6;

  // Following bytes announced by each lead byte form
  localparam logic [PEND_W-1:0] PEND_NONE  = 3'd0;
  localparam logic [PEND_W-1:0] PEND_TWO   = 3'd1;
  localparam logic [PEND_W-1:0] PEND_THREE = 3'd2;
  localparam logic [PEND_W-1:0] PEND_FOUR  = 3'd3;
  localparam logic [PEND_W-1:0] PEND_FIVE  = 3'd4;
  localparam logic [PEND_W-1:0] PEND_SIX   = 3'd5;

  typedef struct packed {
    logic [PEND_W-1:0] bytes_pending;
    logic [CODE_W-1:0] partial_value;
  } dec_state_t;

  typedef struct packed {
    dec_state_t        next_state;
    logic              emit;
    logic              has_code;
    logic [CODE_W-1:0] code_point;
  } dec_step_t;

endpackage

// File: hw/rtl/utf8d_if.sv
// ---------------------------------------------------------------------------
// UTF-8 decoder channel interfaces
// Byte input channel and code point result channel, valid/ready.
// ---------------------------------------------------------------------------
interface utf8d_byte_if;
  import utf8d_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface utf8d_code_if;
  import utf8d_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_point;
  logic              has_code;
  logic              string_done;

  modport source (output valid, output code_point, output has_code, output string_done,
                  input ready);
  modport sink   (input valid, input code_point, input has_code, input string_done,
                  output ready);
endinterface

// File: hw/rtl/utf8d_step.sv
// ---------------------------------------------------------------------------
// UTF-8 decoder step
// Next state and result for one byte, given the current sequence state.
// ---------------------------------------------------------------------------
module utf8d_step (
  input  utf8d_pkg::dec_state_t        cur_state,
  input  logic [utf8d_pkg::BYTE_W-1:0] data_byte,
  input  logic                         final_byte,
  output utf8d_pkg::dec_step_t         step
);
  import utf8d_pkg::*;

  dec_state_t        seq_state;
  logic              done;
  logic [CODE_W-1:0] code;

  // Extend a pending sequence or classify a lead byte
  always_comb begin
    seq_state = cur_state;
    done      = 1'b0;
    code      = '0;
    if (cur_state.bytes_pending != PEND_NONE) begin
      seq_state.partial_value = {cur_state.partial_value[CODE_W-CONT_W-1:0],
                                 data_byte[CONT_W-1:0]};
      seq_state.bytes_pending = cur_state.bytes_pending - 1'b1;
      if (seq_state.bytes_pending == PEND_NONE) begin
        done = 1'b1;
        code = seq_state.partial_value;
      end
    end else begin
      unique casez (data_byte)
        8'b0???????: begin
          done = 1'b1;
          code = {{(CODE_W-BYTE_W){1'b0}}, data_byte};
        end
        8'b110?????: begin
          seq_state.partial_value = {{(CODE_W-5){1'b0}}, data_byte[4:0]};
          seq_state.bytes_pending = PEND_TWO;
        end
        8'b1110????: begin
          seq_state.partial_value = {{(CODE_W-4){1'b0}}, data_byte[3:0]};
          seq_state.bytes_pending = PEND_THREE;
        end
        8'b11110???: begin
          seq_state.partial_value = {{(CODE_W-3){1'b0}}, data_byte[2:0]};
          seq_state.bytes_pending = PEND_FOUR;
        end
        8'b111110??: begin
          seq_state.partial_value = {{(CODE_W-2){1'b0}}, data_byte[1:0]};
          seq_state.bytes_pending = PEND_FIVE;
        end
        8'b1111110?: begin
          seq_state.partial_value = {{(CODE_W-1){1'b0}}, data_byte[0]};
          seq_state.bytes_pending = PEND_SIX;
        end
        // stray continuation byte or 0xFE/0xFF: skip
        8'b10??????, 8'b1111111?: begin
          seq_state = cur_state;
        end
        default: begin
          seq_state = cur_state;
        end
      endcase
    end
  end

  // Clear on end of string or on a finished character
  always_comb begin
    step.next_state = seq_state;
    if (final_byte || done) begin
      step.next_state.partial_value = '0;
    end
    if (final_byte) begin
      step.next_state.bytes_pending = PEND_NONE;
    end
    step.emit       = done | final_byte;
    step.has_code   = done;
    step.code_point = code;
  end

endmodule

// File: hw/rtl/utf8_byte_stream_decoder.sv
// ---------------------------------------------------------------------------
// UTF-8 byte stream decoder
// Decodes the original six-byte UTF-8 form, one byte per beat.
//
//   channel    dir  payload                                  handshake
//   byte_in    in   data_byte[7:0], final_byte               valid/ready
//   code_out   out  code_point[30:0], has_code, string_done  valid/ready
//
// One byte per cycle sustained unless a held result stalls; a byte's result loads
// the result register as the byte leaves the input register, then drives the result beat.
// The sequence state is updated as a byte leaves the input register, so the
// decode step is a single mask-and-shift between the two registers.
// A stalled result holds the result register; bytes that make no result pass.
// Synchronous reset clears the sequence state and both valid flags.
// ---------------------------------------------------------------------------
module utf8_byte_stream_decoder (
  input  logic          clk,
  input  logic          rst,
  utf8d_byte_if.sink    byte_in,
  utf8d_code_if.source  code_out
);
  import utf8d_pkg::*;

  `include "utf8_byte_stream_decoder_assert.svh"

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_final;
  dec_state_t        dec_state;
  dec_step_t         step;
  logic              out_valid;
  logic [CODE_W-1:0] out_code;
  logic              out_has;
  logic              out_done;
  logic              out_free;
  logic              s1_move;
  logic              out_stall;

  utf8d_step u_step (
    .cur_state  (dec_state),
    .data_byte  (s1_byte),
    .final_byte (s1_final),
    .step       (step)
  );

  // Advance the input register when its byte can leave
  assign out_free      = !out_valid || code_out.ready;
  assign s1_move       = s1_valid && (!step.emit || out_free);
  assign byte_in.ready = !s1_valid || s1_move;
  assign out_stall     = out_valid && !code_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      dec_state <= '0;
    end else begin
      // load the next beat
      if (byte_in.ready) begin
        s1_valid <= byte_in.valid;
      end
      // commit sequence state
      if (s1_move) begin
        dec_state <= step.next_state;
      end
      // hold or replace the result
      if (s1_move && step.emit) begin
        out_valid <= 1'b1;
      end else if (code_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      s1_byte  <= byte_in.data_byte;
      s1_final <= byte_in.final_byte;
    end
    if (s1_move && step.emit) begin
      out_code <= step.code_point;
      out_has  <= step.has_code;
      out_done <= s1_final;
    end
  end

  assign code_out.valid       = out_valid;
  assign code_out.code_point  = out_code;
  assign code_out.has_code    = out_has;
  assign code_out.string_done = out_done;

  // A result without a character only marks the end of the string
  `UTF8D_ASSERT_NOW(a_empty_is_done, clk, rst, out_valid && !out_has, out_done && (out_code == '0))
  // The end of the string leaves the sequence state cleared
  `UTF8D_ASSERT_NEXT(a_final_clears, clk, rst, s1_move && s1_final, dec_state == '0)
  // At most five following bytes are ever pending
  `UTF8D_ASSERT_NOW(a_pending_range, clk, rst, 1'b1, dec_state.bytes_pending <= PEND_SIX)
  // A stalled result stays put
  `UTF8D_ASSERT_NEXT(a_result_holds, clk, rst, out_stall, out_valid && $stable({out_code, out_done}))

endmodule

// File: tb/sv/utf8_decode_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UTF-8 decoder result checker
// Watches both channels of the decoder, decodes every accepted byte with its
// own model of the six-byte sequence state, and compares each result beat
// field by field against the oldest predicted code point.
// ---------------------------------------------------------------------------
module utf8_decode_checker (
  input  logic  clk,
  input  logic  rst,
  utf8d_byte_if byte_mon,
  utf8d_code_if code_mon,
  output int    mismatch_count,
  output int    codes_outstanding
);
  import utf8d_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] code_point;
    logic              has_code;
    logic              string_done;
  } code_beat_t;

  code_beat_t        expected_codes[$];
  logic [PEND_W-1:0] cont_left;
  logic [CODE_W-1:0] partial_code;
  int                errors;

  // Advance the sequence state by one byte; queue the result it causes, if any
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
    code_beat_t res;
    res = '0;
    if (cont_left != PEND_NONE) begin
      // continuation byte: top two bits are not checked
      partial_code = {partial_code[CODE_W-CONT_W-1:0], b[CONT_W-1:0]};
      cont_left = cont_left - 1'b1;
      if (cont_left == PEND_NONE) begin
        res.has_code   = 1'b1;
        res.code_point = partial_code;
      end
    end else if (!b[7]) begin
      res.has_code   = 1'b1;
      res.code_point = CODE_W'(b);
    end else if (b[7:5] == 3'b110) begin
      partial_code = CODE_W'(b[4:0]);
      cont_left    = PEND_TWO;
    end else if (b[7:4] == 4'b1110) begin
      partial_code = CODE_W'(b[3:0]);
      cont_left    = PEND_THREE;
    end else if (b[7:3] == 5'b11110) begin
      partial_code = CODE_W'(b[2:0]);
      cont_left    = PEND_FOUR;
    end else if (b[7:2] == 6'b111110) begin
      partial_code = CODE_W'(b[1:0]);
      cont_left    = PEND_FIVE;
    end else if (b[7:1] == 7'b1111110) begin
      partial_code = CODE_W'(b[0]);
      cont_left    = PEND_SIX;
    end
    // stray continuation or 0xFE/0xFF lead: skip it

    // end of string drops any partial character
    if (last) begin
      cont_left    = PEND_NONE;
      partial_code = '0;
    end else if (res.has_code) begin
      partial_code = '0;
    end

    if (res.has_code || last) begin
      res.string_done = last;
      expected_codes = {expected_codes, res};
    end
  endtask

  always @(posedge clk) begin
    code_beat_t want;
    logic       bad;
    if (rst) begin
      cont_left    = PEND_NONE;
      partial_code = '0;
      expected_codes.delete();
      errors       = 0;
    end else begin
      if (byte_mon.valid && byte_mon.ready)
        decode_byte(byte_mon.data_byte, byte_mon.final_byte);

      // compare each result beat against the oldest prediction
      if (code_mon.valid && code_mon.ready) begin
        if (expected_codes.size() == 0) begin
          $display("%0t: result with nothing expected: code_point=%h has_code=%b string_done=%b",
                   $time, code_mon.code_point, code_mon.has_code, code_mon.string_done);
          errors++;
        end else begin
          want = expected_codes.pop_front();
          bad  = 1'b0;
          if (code_mon.code_point !== want.code_point) begin
            $display("%0t: code_point expected %h actual %h",
                     $time, want.code_point, code_mon.code_point);
            bad = 1'b1;
          end
          if (code_mon.has_code !== want.has_code) begin
            $display("%0t: has_code expected %b actual %b",
                     $time, want.has_code, code_mon.has_code);
            bad = 1'b1;
          end
          if (code_mon.string_done !== want.string_done) begin
            $display("%0t: string_done expected %b actual %b",
                     $time, want.string_done, code_mon.string_done);
            bad = 1'b1;
          end
          if (bad)
            errors++;
        end
      end
    end
    mismatch_count    <= errors;
    codes_outstanding <= expected_codes.size();
  end

endmodule

// File: tb/sv/utf8_byte_stream_decoder_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UTF-8 byte stream decoder testbench
// Drives directed strings covering every lead byte form, stray and invalid
// leads and truncated sequences, then random strings made mostly of
// well-formed sequences, with random gaps and result stalls on both sides.
// ---------------------------------------------------------------------------
module utf8_byte_stream_decoder_test;
  import utf8d_pkg::*;

  localparam int BYTE_TARGET  = 1900;
  localparam int STALL_LIMIT  = 200;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst;
  bit   steady;
  int   bytes_sent;
  int   idle_cycles;
  int   mismatch_count;
  int   codes_outstanding;

  utf8d_byte_if byte_ch ();
  utf8d_code_if code_ch ();

  utf8_byte_stream_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_ch),
    .code_out (code_ch)
  );

  utf8_decode_checker chk (
    .clk               (clk),
    .rst               (rst),
    .byte_mon          (byte_ch),
    .code_mon          (code_ch),
    .mismatch_count    (mismatch_count),
    .codes_outstanding (codes_outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Send one byte beat after a random gap; return once it is accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      byte_ch.valid <= 1'b0;
    end
    @(negedge clk);
    byte_ch.valid      <= 1'b1;
    byte_ch.data_byte  <= b;
    byte_ch.final_byte <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold the sender until every predicted result has come out
  task automatic wait_drained();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    wait (codes_outstanding == 0);
  endtask

  // Build a string of random characters, with noise and the odd cut-off tail
  task automatic send_random_string();
    logic [BYTE_W-1:0] seq[$];
    logic [BYTE_W-1:0] lead;
    logic [BYTE_W-1:0] nb;
    int                n_chars;
    int                kind;
    int                len;
    int                cut;
    n_chars = $urandom_range(1, 8);
    for (int c = 0; c < n_chars; c++) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        // noise: any byte, often a stray continuation or invalid lead
        nb  = BYTE_W'($urandom);
        seq = {seq, nb};
      end else begin
        len  = (kind < 35) ? 1 : $urandom_range(2, 6);
        lead = BYTE_W'($urandom);
        case (len)
          1:       lead[7]   = 1'b0;
          2:       lead[7:5] = 3'b110;
          3:       lead[7:4] = 4'b1110;
          4:       lead[7:3] = 5'b11110;
          5:       lead[7:2] = 6'b111110;
          default: lead[7:1] = 7'b1111110;
        endcase
        seq = {seq, lead};
        for (int k = 1; k < len; k++) begin
          if ($urandom_range(0, 9) == 0)
            nb = BYTE_W'($urandom);
          else
            nb = {2'b10, CONT_W'($urandom)};
          seq = {seq, nb};
        end
      end
    end
    // cut the tail now and then so the string ends inside a sequence
    if (seq.size() > 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, seq.size() - 1);
      repeat (cut) void'(seq.pop_back());
    end
    foreach (seq[i])
      send_byte(seq[i], i == seq.size() - 1);
  endtask

  // Stimulus and verdict
  initial begin
    rst                = 1'b1;
    steady             = 1'b0;
    bytes_sent         = 0;
    byte_ch.valid      = 1'b0;
    byte_ch.data_byte  = '0;
    byte_ch.final_byte = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one-byte characters at both ends, string ends on a character
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b1);
    // largest two-byte character
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // three-byte character completing on the final byte
    send_byte(8'hEF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b1);
    // four-byte character whose following bytes lack the 10 prefix
    send_byte(8'hF7, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    // largest five-byte character
    send_byte(8'hFB, 1'b0);
    repeat (4) send_byte(8'hBF, 1'b0);
    // largest six-byte character, full 31-bit code point
    send_byte(8'hFD, 1'b0);
    repeat (5) send_byte(8'hBF, 1'b0);
    // stray continuation and invalid leads are skipped; last one ends the string
    send_byte(8'h80, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b1);
    // six-byte sequence cut short by the end of the string
    send_byte(8'hFC, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_drained();

    // random strings, with stretches of no idling and occasional drains
    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 5) == 0)
        steady = !steady;
      if ($urandom_range(0, 39) == 0)
        wait_drained();
      send_random_string();
    end
    @(negedge clk);
    byte_ch.valid <= 1'b0;

    wait (codes_outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && codes_outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Result side: stall a random number of cycles before each beat
  initial begin
    int stall;
    code_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk);
        code_ch.ready <= 1'b0;
      end
      @(negedge clk);
      code_ch.ready <= 1'b1;
      @(posedge clk);
      while (!code_ch.valid) @(posedge clk);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (code_ch.valid && code_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_if.sv
hw/rtl/utf8d_step.sv
hw/rtl/utf8_byte_stream_decoder.sv
tb/sv/utf8_decode_checker.sv
tb/sv/utf8_byte_stream_decoder_test.sv
